// File: src/rns_mma_pkg.sv
// ----------------------------------------------------------------------------
// rns_mma_pkg
// Shared types and constants of the residue-number-system multiply/add block.
// ----------------------------------------------------------------------------
package rns_mma_pkg;

  // register file layout
  localparam int NUM_MODULI = 6;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 31;
  localparam int MOD_W      = 31;
  localparam int MOD_IDX_W  = $clog2(NUM_MODULI);
  localparam int COMP_W     = 3;

  localparam logic [MOD_W-1:0] MOD_RESET = 31'h7FFF_FFFF;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_OPERATION = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MODULUS_0 = 3'd1;

  // defaults for the top-level parameters
  localparam int DEF_MAX_COMPONENTS = 6;
  localparam int DEF_RESIDUE_BITS   = 31;

  typedef enum logic {
    OP_MUL = 1'b0,
    OP_ADD = 1'b1
  } op_t;

  // control that travels with each word along the cell row
  typedef struct packed {
    logic valid;
    logic last;
  } rns_ctl_t;

endpackage

// File: src/rns_mma_cell.sv
// ----------------------------------------------------------------------------
// rns_mma_cell
// One restoring reduction step: shift in one dividend bit, subtract the
// modulus if the partial remainder reaches it, register the result.
// ----------------------------------------------------------------------------
module rns_mma_cell
  import rns_mma_pkg::*;
#(
  parameter int RES_W = DEF_RESIDUE_BITS,
  parameter int DIV_W = 2 * DEF_RESIDUE_BITS
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             adv_i,
  input  logic             pass_i,
  input  rns_ctl_t         ctl_i,
  input  logic [RES_W-1:0] rem_i,
  input  logic [DIV_W-1:0] div_i,
  input  logic [RES_W-1:0] q_i,
  output rns_ctl_t         ctl_o,
  output logic [RES_W-1:0] rem_o,
  output logic [DIV_W-1:0] div_o,
  output logic [RES_W-1:0] q_o
);

  rns_ctl_t         ctl_r;
  logic [RES_W-1:0] rem_r;
  logic [DIV_W-1:0] div_r;
  logic [RES_W-1:0] q_r;

  logic [RES_W:0]   part;
  logic [RES_W:0]   diff;
  logic [RES_W-1:0] rem_nxt;
  logic [DIV_W-1:0] div_nxt;

  always_comb begin
    part    = {rem_i, div_i[DIV_W-1]};
    diff    = part - {1'b0, q_i};
    div_nxt = {div_i[DIV_W-2:0], 1'b0};
    if (pass_i) begin
      rem_nxt = rem_i;
    end else if (part >= {1'b0, q_i}) begin
      rem_nxt = diff[RES_W-1:0];
    end else begin
      rem_nxt = part[RES_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else if (adv_i) begin
      ctl_r <= ctl_i;
    end
  end

  always_ff @(posedge clk) begin
    if (adv_i) begin
      rem_r <= rem_nxt;
      div_r <= div_nxt;
      q_r   <= q_i;
    end
  end

  assign ctl_o = ctl_r;
  assign rem_o = rem_r;
  assign div_o = div_r;
  assign q_o   = q_r;

endmodule

// File: src/rns_mma_obuf.sv
// ----------------------------------------------------------------------------
// rns_mma_obuf
// Two-entry result buffer; decouples the cell row from output stalls.
// ----------------------------------------------------------------------------
module rns_mma_obuf #(
  parameter int DATA_W = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push_i,
  input  logic [DATA_W-1:0] data_i,
  output logic              space_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [DATA_W-1:0] data_o
);

  localparam int DEPTH = 2;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [DATA_W-1:0] slot_r [DEPTH];
  logic              wr_ptr_r;
  logic              rd_ptr_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [CNT_W-1:0]  cnt_nxt;
  logic              pop;

  assign pop         = (cnt_r != '0) && out_ready_i;
  assign out_valid_o = (cnt_r != '0);
  assign space_o     = (cnt_r != CNT_W'(DEPTH));
  assign data_o      = slot_r[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r + CNT_W'(push_i) - CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_i) begin
      slot_r[wr_ptr_r] <= data_i;
    end
  end

endmodule

// File: src/rns_modular_mul_add.sv
// ----------------------------------------------------------------------------
// rns_modular_mul_add
// Element-wise RNS arithmetic: (a*b) mod q or a+b-q (if a+b >= q), q chosen by
// tuple component, built as a row of one-bit restoring reduction cells.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake            | word
//  --------+-----------+----------------------+-----------------------------------
//  in      | input     | in_valid / in_ready  | first/second operand, comp, last
//  out     | output    | out_valid / out_ready| residue_out, last_out
//  cfg     | input     | cfg_we (no wait)     | cfg_index, cfg_wdata
//
//  one word per cycle while the output buffer has room; each word is registered
//    in the front multiply stage and then in one reduction cell per product bit
//  the whole cell row advances together; it stops only when the two-entry
//    output buffer is full, so in_ready comes from a register compare
//  reset clears the valid flags, the buffer pointers and the registers
//    (multiply mode, every modulus at 2^31-1)
//
module rns_modular_mul_add
  import rns_mma_pkg::*;
#(
  parameter int MAX_COMPONENTS = DEF_MAX_COMPONENTS,
  parameter int RESIDUE_BITS   = DEF_RESIDUE_BITS
) (
  input  logic                    clk,
  input  logic                    rst_n,

  // configuration writes
  input  logic                    cfg_we,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [CFG_DATA_W-1:0]   cfg_wdata,

  // operand words
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [RESIDUE_BITS-1:0] in_first_operand,
  input  logic [RESIDUE_BITS-1:0] in_second_operand,
  input  logic [COMP_W-1:0]       in_component,
  input  logic                    in_last_element,

  // result words
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [RESIDUE_BITS-1:0] out_residue_out,
  output logic                    out_last_out
);

  localparam int RB = RESIDUE_BITS;
  localparam int DW = 2 * RESIDUE_BITS;  // product width, one cell per bit

  // configuration registers
  op_t              op_r;
  logic [MOD_W-1:0] mod_r [NUM_MODULI];

  // front stage: product or sum loaded as the dividend of the cell row
  rns_ctl_t         front_ctl_r;
  logic [RB-1:0]    front_rem_r;
  logic [DW-1:0]    front_div_r;
  logic [RB-1:0]    front_q_r;

  logic [RB-1:0]    front_rem_nxt;
  logic [DW-1:0]    front_div_nxt;
  logic [DW-1:0]    prod;
  logic [RB:0]      sum;
  logic [COMP_W-1:0] comp_sel;
  logic [RB-1:0]    q_sel;

  // cell row taps, index 0 is the front stage
  rns_ctl_t         chain_ctl [DW+1];
  logic [RB-1:0]    chain_rem [DW+1];
  logic [DW-1:0]    chain_div [DW+1];
  logic [RB-1:0]    chain_q   [DW+1];

  logic             adv;
  logic             push;
  logic [RB:0]      buf_data;
  logic             buf_space;

  // ---------------------------------------------------------------------------
  // register writes; an index past the last modulus is dropped
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      op_r <= OP_MUL;
      for (int i = 0; i < NUM_MODULI; i++) begin
        mod_r[i] <= MOD_RESET;
      end
    end else if (cfg_we) begin
      if (cfg_index == REG_OPERATION) begin
        op_r <= op_t'(cfg_wdata[0]);
      end
      for (int i = 0; i < NUM_MODULI; i++) begin
        if (cfg_index == REG_MODULUS_0 + CFG_IDX_W'(i)) begin
          mod_r[i] <= cfg_wdata[MOD_W-1:0];
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // front stage
  // ---------------------------------------------------------------------------
  assign adv      = buf_space;
  assign in_ready = adv;

  always_comb begin
    // out-of-range component saturates to the top one
    if (in_component >= COMP_W'(MAX_COMPONENTS)) begin
      comp_sel = COMP_W'(MAX_COMPONENTS - 1);
    end else begin
      comp_sel = in_component;
    end
    q_sel = mod_r[comp_sel[MOD_IDX_W-1:0]][RB-1:0];

    prod = DW'(in_first_operand) * DW'(in_second_operand);
    sum  = {1'b0, in_first_operand} + {1'b0, in_second_operand};

    // add mode: first cell sees the whole sum as its partial remainder,
    // later cells pass it through, so q comes off at most once
    unique case (op_r)
      OP_ADD: begin
        front_rem_nxt = sum[RB:1];
        front_div_nxt = {sum[0], {(DW-1){1'b0}}};
      end
      OP_MUL: begin
        front_rem_nxt = '0;
        front_div_nxt = prod;
      end
      default: begin
        front_rem_nxt = '0;
        front_div_nxt = prod;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_ctl_r <= '0;
    end else if (adv) begin
      front_ctl_r.valid <= in_valid;
      front_ctl_r.last  <= in_last_element;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      front_rem_r <= front_rem_nxt;
      front_div_r <= front_div_nxt;
      front_q_r   <= q_sel;
    end
  end

  assign chain_ctl[0] = front_ctl_r;
  assign chain_rem[0] = front_rem_r;
  assign chain_div[0] = front_div_r;
  assign chain_q[0]   = front_q_r;

  // ---------------------------------------------------------------------------
  // reduction row: one dividend bit per cell, msb first
  // ---------------------------------------------------------------------------
  for (genvar k = 0; k < DW; k++) begin : g_cell
    rns_mma_cell #(
      .RES_W (RB),
      .DIV_W (DW)
    ) u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .adv_i  (adv),
      .pass_i ((k == 0) ? 1'b0 : (op_r == OP_ADD)),
      .ctl_i  (chain_ctl[k]),
      .rem_i  (chain_rem[k]),
      .div_i  (chain_div[k]),
      .q_i    (chain_q[k]),
      .ctl_o  (chain_ctl[k+1]),
      .rem_o  (chain_rem[k+1]),
      .div_o  (chain_div[k+1]),
      .q_o    (chain_q[k+1])
    );
  end

  // ---------------------------------------------------------------------------
  // output buffer
  // ---------------------------------------------------------------------------
  assign push = chain_ctl[DW].valid && adv;

  rns_mma_obuf #(
    .DATA_W (RB + 1)
  ) u_obuf (
    .clk         (clk),
    .rst_n       (rst_n),
    .push_i      (push),
    .data_i      ({chain_ctl[DW].last, chain_rem[DW]}),
    .space_o     (buf_space),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .data_o      (buf_data)
  );

  assign out_residue_out = buf_data[RB-1:0];
  assign out_last_out    = buf_data[RB];

  // ---------------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------------

  // an empty buffer always has room, so input is never refused then
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("in_ready low with empty output buffer");

  // a stalled row must keep its tail word in place
  a_tail_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (!adv && chain_ctl[DW].valid) |=> chain_ctl[DW].valid)
    else $error("tail word lost during stall");

  // restoring reduction keeps the remainder below a nonzero modulus
  a_rem_below_q: assert property (@(posedge clk) disable iff (!rst_n)
    (chain_ctl[DW].valid && op_r == OP_MUL && chain_q[DW] != '0)
      |-> (chain_rem[DW] < chain_q[DW]))
    else $error("remainder not reduced below modulus");

  // every product bit has been shifted through by the end of the row
  a_div_consumed: assert property (@(posedge clk) disable iff (!rst_n)
    chain_ctl[DW].valid |-> (chain_div[DW] == '0))
    else $error("dividend bits left at end of row");

endmodule
